### design/ntfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfv_pkg
// Shared widths, character codes, status codes, register indexes and types
// for the numeric text field validator.
// ----------------------------------------------------------------------------
package ntfv_pkg;

    // Digit store depth, also the widest output field
    localparam int MAX_WIDTH = 32;

    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = $clog2(MAX_WIDTH + 2);   // holds MAX_WIDTH+1
    localparam int DEC_W     = 6;                       // holds DECS_CAP
    localparam int SUM_W     = $clog2(MAX_WIDTH + 66);  // digits plus padding
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 6;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_WIDTH + 1);
    localparam logic [DEC_W-1:0] DECS_CAP = DEC_W'(32);

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result status codes
    localparam logic [3:0] STAT_OK          = 4'd0;
    localparam logic [3:0] STAT_MULTI_SIGN  = 4'd1;
    localparam logic [3:0] STAT_SIGN_REJ    = 4'd2;
    localparam logic [3:0] STAT_BAD_FIN     = 4'd3;
    localparam logic [3:0] STAT_MULTI_POINT = 4'd4;
    localparam logic [3:0] STAT_DECS_REJ    = 4'd5;
    localparam logic [3:0] STAT_INVALID     = 4'd6;
    localparam logic [3:0] STAT_DECS_HIDDEN = 4'd7;
    localparam logic [3:0] STAT_DECS_OVER   = 4'd8;
    localparam logic [3:0] STAT_TOO_MANY    = 4'd9;

    // Sign state codes
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;
    localparam logic [1:0] SIGN_OPEN  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMALS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THOUSANDS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMMA_PT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECS_WANT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIDE_DECS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WID  = 3'd7;

    typedef struct packed {
        logic       signed_enable;
        logic       decimals_enable;
        logic       zero_fill;
        logic       thousands_enable;
        logic       comma_is_point;
        logic [4:0] decimals_wanted;
        logic       hide_decimals;
        logic [5:0] field_width;
    } cfg_t;

    // Scan state seen by the finishing sequencer
    typedef struct packed {
        logic [CNT_W-1:0] digit_count;
        logic [DEC_W-1:0] decimals_seen;
        logic [1:0]       sign_state;
        logic             point_seen;
        logic             all_zero;
        logic [3:0]       error_code;
    } run_t;

    typedef enum logic [2:0] {
        FSM_SCAN,
        FSM_LOAD,
        FSM_CHECK,
        FSM_ERR,
        FSM_EMIT
    } fsm_state_t;

endpackage

### design/ntfv_digit_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfv_digit_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ntfv_digit_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/ntfv_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfv_scan
// Per-character scan: classifies each character, updates the run state and
// writes digits into the digit store.
// ----------------------------------------------------------------------------
module ntfv_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ntfv_pkg::cfg_t              cfg,
    input  logic                        accept,
    input  logic                        has_char,
    input  logic [7:0]                  text_char,
    input  logic                        clear_run,
    output ntfv_pkg::run_t              run,
    output logic                        wr_en,
    output logic [ntfv_pkg::ADDR_W-1:0] wr_addr,
    output logic [3:0]                  wr_data
);
    import ntfv_pkg::*;

    run_t run_reg, run_next;
    logic stopped_reg, stopped_next;

    logic [7:0] pt_char;
    logic [7:0] thou_char;
    logic       sep_on;
    logic       is_digit;

    assign pt_char   = cfg.comma_is_point ? CH_COMMA : CH_POINT;
    assign thou_char = cfg.comma_is_point ? CH_POINT : CH_COMMA;
    assign sep_on    = cfg.thousands_enable && !cfg.zero_fill;
    assign is_digit  = (text_char >= CH_ZERO) && (text_char <= CH_NINE);

    assign wr_addr = run_reg.digit_count[ADDR_W-1:0];
    assign wr_data = text_char[3:0];

    always_comb
    begin
        run_next     = run_reg;
        stopped_next = stopped_reg;
        wr_en        = 1'b0;
        if (accept && has_char && (run_reg.error_code == STAT_OK) && !stopped_reg)
        begin
            priority if (is_digit)
            begin
                if (text_char != CH_ZERO)
                begin
                    run_next.all_zero = 1'b0;
                end
                wr_en = (run_reg.digit_count < CNT_W'(MAX_WIDTH));
                if (run_reg.digit_count < CNT_MAX)
                begin
                    run_next.digit_count = run_reg.digit_count + 1'b1;
                end
                if (run_reg.point_seen && (run_reg.decimals_seen < DECS_CAP))
                begin
                    run_next.decimals_seen = run_reg.decimals_seen + 1'b1;
                end
            end
            else if ((text_char == CH_MINUS) || (text_char == CH_PLUS)
                     || (text_char == CH_OPEN))
            begin
                priority if (run_reg.sign_state != SIGN_NONE)
                    run_next.error_code = STAT_MULTI_SIGN;
                else if (!cfg.signed_enable)
                    run_next.error_code = STAT_SIGN_REJ;
                else if (text_char == CH_MINUS)
                    run_next.sign_state = SIGN_MINUS;
                else if (text_char == CH_PLUS)
                    run_next.sign_state = SIGN_PLUS;
                else
                    run_next.sign_state = SIGN_OPEN;
            end
            else if (text_char == CH_CLOSE)
            begin
                if (run_reg.sign_state == SIGN_OPEN)
                    run_next.sign_state = SIGN_MINUS;
                else
                    run_next.error_code = STAT_BAD_FIN;
            end
            else if (text_char == CH_SPACE)
            begin
                if (run_reg.digit_count != '0)
                    stopped_next = 1'b1;
            end
            else if (text_char == pt_char)
            begin
                priority if (run_reg.point_seen)
                    run_next.error_code = STAT_MULTI_POINT;
                else if (cfg.decimals_enable)
                    run_next.point_seen = 1'b1;
                else
                    run_next.error_code = STAT_DECS_REJ;
            end
            else if (!(sep_on && (text_char == thou_char)))
            begin
                run_next.error_code = STAT_INVALID;
            end
        end
        if (clear_run)
        begin
            run_next.digit_count   = '0;
            run_next.decimals_seen = '0;
            run_next.sign_state    = SIGN_NONE;
            run_next.point_seen    = 1'b0;
            run_next.all_zero      = 1'b1;
            run_next.error_code    = STAT_OK;
            stopped_next           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg.digit_count   <= '0;
            run_reg.decimals_seen <= '0;
            run_reg.sign_state    <= SIGN_NONE;
            run_reg.point_seen    <= 1'b0;
            run_reg.all_zero      <= 1'b1;
            run_reg.error_code    <= STAT_OK;
            stopped_reg           <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            stopped_reg <= stopped_next;
        end
    end

    assign run = run_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg.digit_count <= CNT_MAX)
        else $error("digit count past saturation");

    a_decs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg.decimals_seen <= DECS_CAP)
        else $error("decimal count past saturation");
`endif

endmodule

### design/ntfv_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfv_emit
// End-of-text sequencer: final checks, padding, and field output through a
// registered output stage, reading digits back from the store.
// ----------------------------------------------------------------------------
module ntfv_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ntfv_pkg::cfg_t              cfg,
    input  ntfv_pkg::run_t              run,
    input  logic                        start,
    output logic                        busy,
    output logic                        clear_run,
    output logic                        rd_en,
    output logic [ntfv_pkg::ADDR_W-1:0] rd_addr,
    input  logic [3:0]                  rd_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_char,
    output logic [3:0]                  status,
    output logic                        last_out
);
    import ntfv_pkg::*;

    fsm_state_t state_reg, state_next;

    logic [SUM_W-1:0] p_reg, p_next;
    logic [SUM_W-1:0] lead_reg, lead_next;
    logic [3:0]       code_reg, code_next;
    logic             data_ok_reg, data_ok_next;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic [3:0]       status_reg;
    logic             last_reg;

    logic [SUM_W-1:0] w_c;
    logic [SUM_W-1:0] fw_c;
    logic [SUM_W-1:0] cnt_c;
    logic [SUM_W-1:0] total_c;
    logic [4:0]       wanted_c;
    logic [3:0]       code_c;

    logic             slot_free;
    logic             p_last;
    logic             out_load;
    logic [SUM_W-1:0] q_c;
    logic [SUM_W-1:0] rd_pos;
    logic [SUM_W-1:0] rd_full;
    logic [7:0]       char_c;

    // field width clamped into 1..MAX_WIDTH
    assign fw_c = SUM_W'(cfg.field_width);
    always_comb
    begin
        priority if (fw_c == '0)
            w_c = SUM_W'(1);
        else if (fw_c > SUM_W'(MAX_WIDTH))
            w_c = SUM_W'(MAX_WIDTH);
        else
            w_c = fw_c;
    end

    // final checks; rd_data holds store entry 0 in the check state
    assign cnt_c    = SUM_W'(run.digit_count);
    assign wanted_c = cfg.decimals_enable ? cfg.decimals_wanted : 5'd0;
    always_comb
    begin
        code_c  = run.error_code;
        total_c = cnt_c;
        if ((code_c == STAT_OK) && cfg.decimals_enable)
        begin
            priority if (cfg.hide_decimals && run.point_seen)
                code_c = STAT_DECS_HIDDEN;
            else if (SUM_W'(run.decimals_seen) > SUM_W'(wanted_c))
                code_c = STAT_DECS_OVER;
            else
                total_c = cnt_c + SUM_W'(wanted_c) - SUM_W'(run.decimals_seen);
        end
        if ((code_c == STAT_OK) && (total_c > w_c))
        begin
            code_c = STAT_TOO_MANY;
        end
        if ((code_c == STAT_OK) && cfg.signed_enable)
        begin
            // a non-zero digit would land in the sign place
            priority if ((total_c == w_c) && (cnt_c != '0) && (rd_data != 4'd0))
                code_c = STAT_TOO_MANY;
            else if (run.sign_state == SIGN_OPEN)
                code_c = STAT_BAD_FIN;
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign p_last    = (p_reg == (w_c - 1'b1));

    // character for position p_reg
    assign q_c = p_reg - lead_reg;
    always_comb
    begin
        if ((p_reg >= lead_reg) && (q_c < cnt_c))
            char_c = CH_ZERO + {4'd0, rd_data};
        else
            char_c = CH_ZERO;
        if ((p_reg == '0) && cfg.signed_enable)
        begin
            priority if (run.all_zero)
                char_c = CH_SPACE;
            else if (run.sign_state == SIGN_MINUS)
                char_c = CH_MINUS;
            else
                char_c = CH_PLUS;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_SCAN:
            begin
                if (start)
                    state_next = FSM_LOAD;
            end
            FSM_LOAD:
                state_next = FSM_CHECK;
            FSM_CHECK:
                state_next = (code_c != STAT_OK) ? FSM_ERR : FSM_EMIT;
            FSM_ERR:
            begin
                if (slot_free)
                    state_next = FSM_SCAN;
            end
            FSM_EMIT:
            begin
                if (data_ok_reg && slot_free && p_last)
                    state_next = FSM_SCAN;
            end
            default:
                state_next = FSM_SCAN;
        endcase
    end

    // control outputs
    always_comb
    begin
        busy      = 1'b1;
        rd_en     = 1'b0;
        rd_pos    = p_reg;
        out_load  = 1'b0;
        clear_run = 1'b0;
        unique case (state_reg)
            FSM_SCAN:
                busy = 1'b0;
            FSM_LOAD:
            begin
                rd_en  = 1'b1;
                rd_pos = lead_reg;   // overridden below: entry 0
            end
            FSM_CHECK:
                ;
            FSM_ERR:
            begin
                out_load  = slot_free;
                clear_run = slot_free;
            end
            FSM_EMIT:
            begin
                if (!data_ok_reg)
                begin
                    rd_en = 1'b1;
                end
                else if (slot_free)
                begin
                    out_load  = 1'b1;
                    clear_run = p_last;
                    rd_en     = !p_last;
                    rd_pos    = p_reg + 1'b1;
                end
            end
            default:
                ;
        endcase
    end

    assign rd_full = rd_pos - lead_reg;
    assign rd_addr = (state_reg == FSM_LOAD) ? '0 : rd_full[ADDR_W-1:0];

    // sequencer datapath
    always_comb
    begin
        p_next       = p_reg;
        lead_next    = lead_reg;
        code_next    = code_reg;
        data_ok_next = data_ok_reg;
        if (state_reg == FSM_CHECK)
        begin
            p_next       = '0;
            lead_next    = w_c - total_c;
            code_next    = code_c;
            data_ok_next = 1'b0;
        end
        else if (state_reg == FSM_EMIT)
        begin
            data_ok_next = 1'b1;
            if (out_load && !p_last)
                p_next = p_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_SCAN;
            data_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            data_ok_reg <= data_ok_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        lead_reg <= lead_next;
        code_reg <= code_next;
        if (out_load)
        begin
            if (state_reg == FSM_ERR)
            begin
                out_char_reg <= CH_NUL;
                status_reg   <= code_reg;
                last_reg     <= 1'b1;
            end
            else
            begin
                out_char_reg <= char_c;
                status_reg   <= STAT_OK;
                last_reg     <= p_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign status    = status_reg;
    assign last_out  = last_reg;

`ifndef SYNTHESIS
    a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_EMIT) |-> (p_reg < w_c))
        else $error("output position beyond field width");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (state_reg == FSM_ERR))
        |=> (out_valid_reg && last_reg && (status_reg != STAT_OK)))
        else $error("error result not single and final");

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (status_reg == STAT_OK))
        else $error("non-final result carries an error status");
`endif

endmodule

### design/numeric_text_field_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_text_field_validator
// Checks an ASCII number string against a configured format and emits the
// padded field, signed when so configured, one character per result, or a
// single error result.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  input   | in_valid / in_stall   | has_char, text_char, end_of_text
//  output  | out_valid / out_stall | out_char, status, last_out
//  config  | cfg_write             | cfg_index, cfg_data
//
//  Scan: one character a cycle while in_stall is low, digits written into
//  the store RAM. End item: FSM_LOAD reads store entry 0, FSM_CHECK runs the
//  final checks; then FSM_ERR loads an error result, or FSM_EMIT primes the
//  RAM read, then loads one character a cycle while out_stall does not hold
//  the output register full, the clamped field width in all.
//  in_stall stays high from the end item until its last result is in the
//  output register; the next string can then start while it waits.
//  Reset: asynchronous, clears run, control and config state; the store has
//  no clearing pass since only digits written in the current run are read.
// ----------------------------------------------------------------------------
module numeric_text_field_validator (
    input  logic                           clk,
    input  logic                           rst_n,
    // input requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           has_char,
    input  logic [7:0]                     text_char,
    input  logic                           end_of_text,
    // result requests
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_char,
    output logic [3:0]                     status,
    output logic                           last_out,
    // configuration writes
    input  logic                           cfg_write,
    input  logic [ntfv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ntfv_pkg::CFG_DAT_W-1:0] cfg_data
);
    import ntfv_pkg::*;

    cfg_t cfg_reg;

    logic              in_accept;
    logic              busy;
    logic              clear_run;
    run_t              run;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [3:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [3:0]        rd_data;

    // configuration registers; to be written only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signed_enable    <= 1'b0;
            cfg_reg.decimals_enable  <= 1'b0;
            cfg_reg.zero_fill        <= 1'b0;
            cfg_reg.thousands_enable <= 1'b0;
            cfg_reg.comma_is_point   <= 1'b0;
            cfg_reg.decimals_wanted  <= 5'd0;
            cfg_reg.hide_decimals    <= 1'b0;
            cfg_reg.field_width      <= 6'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIGNED:    cfg_reg.signed_enable    <= cfg_data[0];
                REG_DECIMALS:  cfg_reg.decimals_enable  <= cfg_data[0];
                REG_ZERO_FILL: cfg_reg.zero_fill        <= cfg_data[0];
                REG_THOUSANDS: cfg_reg.thousands_enable <= cfg_data[0];
                REG_COMMA_PT:  cfg_reg.comma_is_point   <= cfg_data[0];
                REG_DECS_WANT: cfg_reg.decimals_wanted  <= cfg_data[4:0];
                REG_HIDE_DECS: cfg_reg.hide_decimals    <= cfg_data[0];
                REG_FIELD_WID: cfg_reg.field_width      <= cfg_data[5:0];
            endcase
        end
    end

    // input taken only while the sequencer is not finishing a string
    assign in_stall  = busy;
    assign in_accept = in_valid && !in_stall;

    ntfv_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (in_accept),
        .has_char  (has_char),
        .text_char (text_char),
        .clear_run (clear_run),
        .run       (run),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // digit store: one write port for the scan, one read port for output
    ntfv_digit_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (4)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // end item: the scan update of that item lands first, the sequencer then
    // works from the registered run state
    ntfv_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .run       (run),
        .start     (in_accept && end_of_text),
        .busy      (busy),
        .clear_run (clear_run),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .status    (status),
        .last_out  (last_out)
    );

endmodule

### bench/tb_numeric_text_field_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_numeric_text_field_validator
// Self-checking bench: feeds number strings, one character per request, under
// a series of field formats, predicts each formatted field or error result,
// and checks every result request field by field with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_numeric_text_field_validator;
    import ntfv_pkg::*;

    // One input request as the bench queues it
    typedef struct {
        logic       has_char;
        logic [7:0] text_char;
        logic       end_of_text;
    } text_req_t;

    // One result request as the format model predicts it
    typedef struct {
        logic [7:0] out_char;
        logic [3:0] status;
        logic       last_out;
    } field_res_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic                 has_char    = 1'b0;
    logic [7:0]           text_char   = 8'h00;
    logic                 end_of_text = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [7:0]           out_char;
    logic [3:0]           status;
    logic                 last_out;
    logic                 cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_DAT_W-1:0] cfg_data    = '0;

    text_req_t  text_pending[$];     // requests waiting for the driver
    field_res_t field_chars_due[$];  // predicted results, oldest first
    int         error_count = 0;

    // Format model: register copy plus the scan state of the current string
    cfg_t       fmt;
    logic [3:0] digits [MAX_WIDTH];
    int         dcount;
    int         dseen;
    logic [1:0] sign_st;
    logic       pt_seen;
    logic       all_z;
    logic       stopped;
    logic [3:0] err;

    numeric_text_field_validator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .has_char    (has_char),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .status      (status),
        .last_out    (last_out),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Format model
    // ------------------------------------------------------------------------

    function automatic void restart_scan();
        foreach (digits[i])
            digits[i] = 4'd0;
        dcount  = 0;
        dseen   = 0;
        sign_st = SIGN_NONE;
        pt_seen = 1'b0;
        all_z   = 1'b1;
        stopped = 1'b0;
        err     = STAT_OK;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        logic [7:0] pt;
        logic [7:0] sepc;
        pt = fmt.comma_is_point ? CH_COMMA : CH_POINT;
        // zero fill turns the separator off; a space never reaches that test
        sepc = (fmt.thousands_enable && !fmt.zero_fill)
               ? (fmt.comma_is_point ? CH_POINT : CH_COMMA) : CH_SPACE;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (c != CH_ZERO)
                all_z = 1'b0;
            // digits past the store are counted, not kept; count saturates
            if (dcount < MAX_WIDTH)
                digits[dcount] = 4'(c - CH_ZERO);
            if (dcount < MAX_WIDTH + 1)
                dcount++;
            if (pt_seen && dseen < DECS_CAP)
                dseen++;
        end
        else if (c == CH_MINUS || c == CH_PLUS || c == CH_OPEN)
        begin
            if (sign_st != SIGN_NONE)
                err = STAT_MULTI_SIGN;
            else if (!fmt.signed_enable)
                err = STAT_SIGN_REJ;
            else if (c == CH_MINUS)
                sign_st = SIGN_MINUS;
            else if (c == CH_PLUS)
                sign_st = SIGN_PLUS;
            else
                sign_st = SIGN_OPEN;
        end
        else if (c == CH_CLOSE)
        begin
            if (sign_st == SIGN_OPEN)
                sign_st = SIGN_MINUS;
            else
                err = STAT_BAD_FIN;
        end
        else if (c == CH_SPACE)
        begin
            if (dcount > 0)
                stopped = 1'b1;
        end
        else if (c == pt)
        begin
            if (pt_seen)
                err = STAT_MULTI_POINT;
            else if (fmt.decimals_enable)
                pt_seen = 1'b1;
            else
                err = STAT_DECS_REJ;
        end
        else if (c != sepc)
            err = STAT_INVALID;
    endfunction

    // Digit character at place p of a w-wide field holding t digits
    function automatic logic [7:0] field_digit(int p, int w, int t);
        int lead;
        int q;
        lead = w - t;
        if (p < lead)
            return CH_ZERO;
        q = p - lead;
        if (q < dcount && q < MAX_WIDTH)
            return CH_ZERO + 8'(digits[q]);
        return CH_ZERO;
    endfunction

    // End of string: pad, run the final checks, queue the field or the error
    function automatic void close_field();
        field_res_t r;
        int         w;
        int         wanted;
        int         total;
        logic [3:0] code;
        w = int'(fmt.field_width);
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        wanted = fmt.decimals_enable ? int'(fmt.decimals_wanted) : 0;
        total  = dcount;
        code   = err;
        if (code == STAT_OK && fmt.decimals_enable)
        begin
            if (fmt.hide_decimals && pt_seen)
                code = STAT_DECS_HIDDEN;
            else if (dseen > wanted)
                code = STAT_DECS_OVER;
            else
                total += wanted - dseen;
        end
        if (code == STAT_OK && total > w)
            code = STAT_TOO_MANY;
        // the sign place must be left free by the digits
        if (code == STAT_OK && fmt.signed_enable)
        begin
            if (field_digit(0, w, total) != CH_ZERO)
                code = STAT_TOO_MANY;
            else if (sign_st == SIGN_OPEN)
                code = STAT_BAD_FIN;
        end
        if (code != STAT_OK)
        begin
            r.out_char = CH_NUL;
            r.status   = code;
            r.last_out = 1'b1;
            field_chars_due.push_back(r);
        end
        else
        begin
            for (int p = 0; p < w; p++)
            begin
                r.out_char = field_digit(p, w, total);
                if (p == 0 && fmt.signed_enable)
                begin
                    if (all_z)
                        r.out_char = CH_SPACE;
                    else
                        r.out_char = (sign_st == SIGN_MINUS) ? CH_MINUS : CH_PLUS;
                end
                r.status   = STAT_OK;
                r.last_out = (p + 1 == w);
                field_chars_due.push_back(r);
            end
        end
        restart_scan();
    endfunction

    function automatic void absorb_request(text_req_t r);
        // after an error or a stopping space only the end request matters
        if (r.has_char && err == STAT_OK && !stopped)
            scan_char(r.text_char);
        if (r.end_of_text)
            close_field();
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued requests, predicts each one as it is taken
    // ------------------------------------------------------------------------
    int send_gap   = 0;
    bit send_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        text_req_t taken;
        text_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.has_char    = has_char;
                taken.text_char   = text_char;
                taken.end_of_text = end_of_text;
                absorb_request(taken);
            end
            // payload may only move once the current request has gone
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (text_pending.size() > 0)
                begin
                    nxt = text_pending.pop_front();
                    has_char    <= nxt.has_char;
                    text_char   <= nxt.text_char;
                    end_of_text <= nxt.end_of_text;
                    in_valid    <= 1'b1;
                    // occasional stretches with back-to-back requests
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result requests with random stalls, checks each one
    // ------------------------------------------------------------------------
    int take_gap   = 0;
    bit take_burst = 1'b0;

    function automatic void check_field(string name, logic [7:0] expd, logic [7:0] got);
        if (got !== expd)
        begin
            $error("%s: expected %0h, got %0h", name, expd, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : take_results
        field_res_t due;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (field_chars_due.size() == 0)
                begin
                    $error("unexpected result: out_char %0h status %0d last_out %b",
                           out_char, status, last_out);
                    error_count++;
                end
                else
                begin
                    due = field_chars_due.pop_front();
                    check_field("out_char", due.out_char, out_char);
                    check_field("status", 8'(due.status), 8'(status));
                    check_field("last_out", 8'(due.last_out), 8'(last_out));
                end
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                take_gap = take_burst ? 0 : $urandom_range(0, 5);
            end
            if (take_gap > 0)
            begin
                out_stall <= 1'b1;
                take_gap--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_req(logic has, logic [7:0] c, logic last);
        text_req_t r;
        r.has_char    = has;
        r.text_char   = c;
        r.end_of_text = last;
        text_pending.push_back(r);
    endfunction

    // Whole string, end marked on its last character; empty gives a bare end
    function automatic void queue_text(string s);
        if (s.len() == 0)
            queue_req(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        for (int i = 0; i < s.len(); i++)
            queue_req(1'b1, s[i], i == s.len() - 1);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // Only called with nothing in flight, so the model copy can switch at once
    task automatic write_format(cfg_t c);
        write_reg(REG_SIGNED,    CFG_DAT_W'(c.signed_enable));
        write_reg(REG_DECIMALS,  CFG_DAT_W'(c.decimals_enable));
        write_reg(REG_ZERO_FILL, CFG_DAT_W'(c.zero_fill));
        write_reg(REG_THOUSANDS, CFG_DAT_W'(c.thousands_enable));
        write_reg(REG_COMMA_PT,  CFG_DAT_W'(c.comma_is_point));
        write_reg(REG_DECS_WANT, CFG_DAT_W'(c.decimals_wanted));
        write_reg(REG_HIDE_DECS, CFG_DAT_W'(c.hide_decimals));
        write_reg(REG_FIELD_WID, c.field_width);
        @(posedge clk);
        cfg_write <= 1'b0;
        fmt = c;
    endtask

    task automatic set_format(bit sgn, bit dec, bit zf, bit thou, bit cpt,
                              int want, bit hide, int width);
        cfg_t c;
        c.signed_enable    = sgn;
        c.decimals_enable  = dec;
        c.zero_fill        = zf;
        c.thousands_enable = thou;
        c.comma_is_point   = cpt;
        c.decimals_wanted  = 5'(want);
        c.hide_decimals    = hide;
        c.field_width      = 6'(width);
        write_format(c);
    endtask

    function automatic cfg_t random_format();
        cfg_t c;
        c.signed_enable    = $urandom_range(0, 1);
        c.decimals_enable  = $urandom_range(0, 1);
        c.zero_fill        = $urandom_range(0, 1);
        c.thousands_enable = $urandom_range(0, 1);
        c.comma_is_point   = $urandom_range(0, 1);
        c.hide_decimals    = ($urandom_range(0, 4) == 0);
        // mostly narrow fields, now and then the widest and the out-of-range widths
        case ($urandom_range(0, 9))
            0:       c.field_width = 6'd0;
            1:       c.field_width = 6'd32;
            2:       c.field_width = 6'($urandom_range(33, 63));
            default: c.field_width = 6'($urandom_range(1, 12));
        endcase
        c.decimals_wanted = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                         : 5'($urandom_range(0, 3));
        return c;
    endfunction

    // One random number string shaped by the current format, with some damage.
    // Returns the number of requests that do any work.
    task automatic queue_number(output int used);
        logic [7:0] s[$];
        logic [7:0] pt;
        logic [7:0] sepc;
        int         w;
        int         nint;
        int         ndec;
        bit         zeros;
        bit         paren;
        bit         bare_end;
        pt    = fmt.comma_is_point ? CH_COMMA : CH_POINT;
        sepc  = fmt.comma_is_point ? CH_POINT : CH_COMMA;
        w     = (fmt.field_width == 0) ? 1 : (fmt.field_width > MAX_WIDTH) ? MAX_WIDTH
                                                                         : fmt.field_width;
        nint  = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 36) : $urandom_range(0, w);
        zeros = ($urandom_range(0, 7) == 0);
        paren = 1'b0;
        used  = 0;
        if ($urandom_range(0, 4) == 0)
            s.push_back(CH_SPACE);
        if ($urandom_range(0, fmt.signed_enable ? 3 : 9) < 2)
        begin
            case ($urandom_range(0, 2))
                0: s.push_back(CH_MINUS);
                1: s.push_back(CH_PLUS);
                default:
                begin
                    s.push_back(CH_OPEN);
                    paren = 1'b1;
                end
            endcase
        end
        for (int k = 0; k < nint; k++)
        begin
            s.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
            if (k + 1 < nint &&
                $urandom_range(0, (fmt.thousands_enable && !fmt.zero_fill) ? 3 : 29) == 0)
                s.push_back(sepc);
        end
        if (fmt.decimals_enable ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 7) == 0))
        begin
            s.push_back(pt);
            ndec = $urandom_range(0, int'(fmt.decimals_wanted) + 1);
            for (int k = 0; k < ndec; k++)
                s.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if (paren ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0))
            s.push_back(CH_CLOSE);
        if ($urandom_range(0, 4) == 0)
        begin
            s.push_back(CH_SPACE);
            s.push_back(8'($urandom_range(32, 126)));
        end
        // noise: one character replaced by anything at all
        if (s.size() > 0 && $urandom_range(0, 7) == 0)
            s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
        bare_end = (s.size() == 0) || ($urandom_range(0, 4) == 0);
        foreach (s[i])
        begin
            // idle requests carry no character and do nothing
            if ($urandom_range(0, 15) == 0)
                queue_req(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            queue_req(1'b1, s[i], !bare_end && i == s.size() - 1);
            used++;
        end
        if (bare_end)
        begin
            queue_req(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            used++;
        end
    endtask

    // Drain: nothing queued, nothing presented, nothing predicted, then let
    // the end sequencing settle before the next register write
    task automatic wait_idle();
        do
            @(posedge clk);
        while (text_pending.size() != 0 || in_valid || field_chars_due.size() != 0);
        repeat (MAX_WIDTH + 8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int got;
        int count;
        fmt = '0;
        fmt.field_width = 6'd1;
        restart_scan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset format: one place, unsigned, no decimals; empty string is zero
        queue_text("7");
        queue_text("");
        wait_idle();

        // signed, two decimals, point '.', separator ','
        set_format(1, 1, 0, 1, 0, 2, 0, 12);
        queue_text("-1,2.5");
        queue_text("(3)");
        queue_text("(3");                   // open bracket never closed
        queue_text("+-");                   // second sign
        queue_text("..");                   // second point
        queue_text("0.0");                  // all zero: blank sign place
        queue_req(1'b0, 8'hA5, 1'b0);       // idle request, no effect
        queue_text("1 x");                  // space stops the scan
        queue_req(1'b1, CH_NUL, 1'b1);
        queue_req(1'b1, 8'hFF, 1'b1);
        queue_text("1.234");                // more decimals than wanted
        wait_idle();

        // zero fill over thousands, comma as point, widest field
        set_format(0, 0, 1, 1, 1, 0, 0, 32);
        queue_text("-3");                   // sign not allowed
        queue_text("1,5");                  // decimals not allowed
        queue_text("007.1");                // separator rejected under zero fill
        wait_idle();

        // signed with width 0, which acts as 1: only a zero fits
        set_format(1, 0, 0, 0, 0, 31, 0, 0);
        queue_text("-0");
        queue_text("5");
        wait_idle();

        // hidden decimals, wanted at the top, width above the store
        set_format(0, 1, 0, 0, 1, 31, 1, 63);
        queue_text("1,5");
        queue_text("");
        wait_idle();

        // random formats, each drained before the next register writes
        for (int ph = 0; ph < 6; ph++)
        begin
            write_format(random_format());
            count = 0;
            while (count < 18)
            begin
                queue_number(got);
                count += got;
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
design/ntfv_pkg.sv
design/ntfv_digit_ram.sv
design/ntfv_scan.sv
design/ntfv_emit.sv
design/numeric_text_field_validator.sv
bench/tb_numeric_text_field_validator.sv
